// ===== sv/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared constants and types of the telemetry frame deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int unsigned NUM_AXES_DEF = 6;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  // byte offset of the last byte of an axis record (six bytes per axis)
  localparam logic [2:0] AXIS_LAST_BYTE = 3'd5;

  localparam logic [15:0] THRESHOLD_RESET = 16'd5000;

  // one completed axis, from the hunt/assembly stage
  typedef struct packed {
    logic               fire;
    logic               last;
    logic [2:0]         axis_index;
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic [15:0]        current_ma;
    logic               alert;
    logic               frame_alert;
    logic [7:0]         seq;
  } axis_evt_t;

  // frame statistics as shown on a result
  typedef struct packed {
    logic [31:0] valid_frames;
    logic [31:0] alert_frames;
    logic [31:0] lost_frames;
    logic [7:0]  seq_min;
    logic [7:0]  seq_max;
  } frame_stats_t;

endpackage

// ===== sv/tfd_if.sv =====
// ----------------------------------------------------------------------------
// tfd_if
// Channel interfaces: raw byte in, decoded axis out, threshold write.
// ----------------------------------------------------------------------------
interface tfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tfd_axis_if;
  logic               valid;
  logic               ready;
  logic [2:0]         axis_index;
  logic signed [15:0] position;
  logic signed [15:0] velocity;
  logic [15:0]        current_ma;
  logic               axis_alert;
  logic [7:0]         frame_seq;
  logic               last_axis;
  logic [31:0]        valid_frames;
  logic [31:0]        alert_frames;
  logic [31:0]        lost_frames;
  logic [7:0]         seq_min;
  logic [7:0]         seq_max;

  modport source (
    output valid, output axis_index, output position, output velocity,
    output current_ma, output axis_alert, output frame_seq, output last_axis,
    output valid_frames, output alert_frames, output lost_frames,
    output seq_min, output seq_max, input ready
  );
  modport sink (
    input valid, input axis_index, input position, input velocity,
    input current_ma, input axis_alert, input frame_seq, input last_axis,
    input valid_frames, input alert_frames, input lost_frames,
    input seq_min, input seq_max, output ready
  );
endinterface

interface tfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] current_threshold_ma;

  modport source (output valid, output current_threshold_ma, input ready);
  modport sink   (input valid, input current_threshold_ma, output ready);
endinterface

// ===== sv/tfd_hunt.sv =====
// ----------------------------------------------------------------------------
// tfd_hunt
// Sync hunt, sequence capture and axis word assembly.
// ----------------------------------------------------------------------------
module tfd_hunt import tfd_pkg::*; #(
  parameter int unsigned NumAxes = NUM_AXES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] threshold_i,
  output axis_evt_t   evt_o,
  output logic        fire_next_o
);

  localparam int unsigned AxW = (NumAxes > 1) ? $clog2(NumAxes) : 1;
  localparam logic [AxW-1:0] AxisLast = AxW'(NumAxes - 1);

  localparam logic [1:0] StHunt    = 2'd0;
  localparam logic [1:0] StSawAa   = 2'd1;
  localparam logic [1:0] StSeq     = 2'd2;
  localparam logic [1:0] StPayload = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [2:0]       within_q, within_d;
  logic [AxW-1:0]   axis_q, axis_d;
  logic [7:0]       seq_q, seq_d;
  logic             falert_q, falert_d;
  logic [4:0][7:0]  lanes_q, lanes_d;

  logic [15:0]      cur;
  logic             alert;
  logic             last;
  logic [AxW+2:0]   axis_ext;

  assign cur      = {data_byte_i, lanes_q[4]};
  assign alert    = cur > threshold_i;
  assign last     = axis_q == AxisLast;
  assign axis_ext = {3'b000, axis_q};

  // a result can only come out of the sixth byte of an axis
  assign fire_next_o = (state_q == StPayload) && (within_q == AXIS_LAST_BYTE);

  always_comb begin
    state_d  = state_q;
    within_d = within_q;
    axis_d   = axis_q;
    seq_d    = seq_q;
    falert_d = falert_q;
    lanes_d  = lanes_q;
    evt_o.fire        = 1'b0;
    evt_o.last        = last;
    evt_o.axis_index  = axis_ext[2:0];
    evt_o.position    = {lanes_q[1], lanes_q[0]};
    evt_o.velocity    = {lanes_q[3], lanes_q[2]};
    evt_o.current_ma  = cur;
    evt_o.alert       = alert;
    evt_o.frame_alert = falert_q | alert;
    evt_o.seq         = seq_q;
    if (accept_i) begin
      unique case (state_q)
        StHunt: begin
          if (data_byte_i == SYNC_FIRST) state_d = StSawAa;
        end
        StSawAa: begin
          if (data_byte_i == SYNC_SECOND) begin
            state_d = StSeq;
          end else if (data_byte_i != SYNC_FIRST) begin
            state_d = StHunt;
          end
        end
        StSeq: begin
          seq_d    = data_byte_i;
          within_d = '0;
          axis_d   = '0;
          falert_d = 1'b0;
          state_d  = StPayload;
        end
        StPayload: begin
          if (within_q == AXIS_LAST_BYTE) begin
            evt_o.fire = 1'b1;
            within_d   = '0;
            falert_d   = falert_q | alert;
            if (last) begin
              state_d = StHunt;
              axis_d  = '0;
            end else begin
              axis_d = axis_q + 1'b1;
            end
          end else begin
            lanes_d[within_q] = data_byte_i;
            within_d          = within_q + 3'd1;
          end
        end
        default: state_d = StHunt;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StHunt;
      within_q <= '0;
      axis_q   <= '0;
      seq_q    <= '0;
      falert_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      within_q <= within_d;
      axis_q   <= axis_d;
      seq_q    <= seq_d;
      falert_q <= falert_d;
    end
  end

  // word bytes: every lane is written before it is read within an axis
  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
  end

endmodule

// ===== sv/tfd_stats.sv =====
// ----------------------------------------------------------------------------
// tfd_stats
// Frame counters and sequence bounds, updated when a frame closes.
// ----------------------------------------------------------------------------
module tfd_stats import tfd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         close_i,
  input  logic [7:0]   seq_i,
  input  logic         alert_i,
  output frame_stats_t stats_o
);

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic         first_q, first_d;
  logic [7:0]   prev_q, prev_d;
  frame_stats_t st_q, st_d;
  logic [7:0]   gap;

  // frames missing between the previous and this sequence, modulo 256
  assign gap = seq_i - 8'd1 - prev_q;

  always_comb begin
    st_d    = st_q;
    first_d = first_q;
    prev_d  = prev_q;
    if (close_i) begin
      st_d.valid_frames = sat_add(st_q.valid_frames, 8'd1);
      if (alert_i) st_d.alert_frames = sat_add(st_q.alert_frames, 8'd1);
      if (seq_i < st_q.seq_min) st_d.seq_min = seq_i;
      if (seq_i > st_q.seq_max) st_d.seq_max = seq_i;
      if (!first_q) st_d.lost_frames = sat_add(st_q.lost_frames, gap);
      first_d = 1'b0;
      prev_d  = seq_i;
    end
  end

  // show updated values on the closing axis, unchanged ones otherwise
  assign stats_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q         <= 1'b1;
      prev_q          <= '0;
      st_q.valid_frames <= '0;
      st_q.alert_frames <= '0;
      st_q.lost_frames  <= '0;
      st_q.seq_min      <= 8'hFF;
      st_q.seq_max      <= '0;
    end else begin
      first_q <= first_d;
      prev_q  <= prev_d;
      st_q    <= st_d;
    end
  end

endmodule

// ===== sv/telemetry_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_deframer
// Byte-stream deframer for axis telemetry frames with running statistics.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i  takes one raw stream byte per transfer. The block hunts for the
//           sync pair AA 55, takes a sequence byte, then six bytes per axis.
//   axis_o  gives one decoded axis per transfer, with the alert flag and the
//           frame counters (updated on the last axis of a frame).
//   cfg_i   writes the alert threshold in milliamperes; always ready.
// Throughput: one byte per cycle unless stalled. Latency: an axis result is on
//   axis_o the cycle after its sixth byte is transferred.
// Stall: while a result waits on axis_o, bytes that complete no axis are
//   still taken; only a byte that would complete the next axis is held off.
// Reset: hunt restarts, counters clear, sequence minimum goes to 255, and
//   the threshold returns to 5000 mA.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer import tfd_pkg::*; #(
  parameter int unsigned NumAxes = NUM_AXES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tfd_byte_if.sink         byte_i,
  tfd_axis_if.source       axis_o,
  tfd_cfg_if.sink          cfg_i
);

  logic [15:0]  threshold_q;
  logic         accept;
  logic         fire_next;
  axis_evt_t    evt;
  frame_stats_t stats;

  logic         out_valid_q, out_valid_d;
  axis_evt_t    res_evt_q;
  frame_stats_t res_stats_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_i.valid) begin
      threshold_q <= cfg_i.current_threshold_ma;
    end
  end

  // hold off only the byte that would overwrite a result still waiting
  assign byte_i.ready = !(fire_next && out_valid_q && !axis_o.ready);
  assign accept       = byte_i.valid && byte_i.ready;

  tfd_hunt #(
    .NumAxes(NumAxes)
  ) u_hunt (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .data_byte_i (byte_i.data_byte),
    .threshold_i (threshold_q),
    .evt_o       (evt),
    .fire_next_o (fire_next)
  );

  tfd_stats u_stats (
    .clk_i,
    .rst_ni,
    .close_i (evt.fire && evt.last),
    .seq_i   (evt.seq),
    .alert_i (evt.frame_alert),
    .stats_o (stats)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (evt.fire) begin
      out_valid_d = 1'b1;
    end else if (axis_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt.fire) begin
      res_evt_q   <= evt;
      res_stats_q <= stats;
    end
  end

  assign axis_o.valid        = out_valid_q;
  assign axis_o.axis_index   = res_evt_q.axis_index;
  assign axis_o.position     = res_evt_q.position;
  assign axis_o.velocity     = res_evt_q.velocity;
  assign axis_o.current_ma   = res_evt_q.current_ma;
  assign axis_o.axis_alert   = res_evt_q.alert;
  assign axis_o.frame_seq    = res_evt_q.seq;
  assign axis_o.last_axis    = res_evt_q.last;
  assign axis_o.valid_frames = res_stats_q.valid_frames;
  assign axis_o.alert_frames = res_stats_q.alert_frames;
  assign axis_o.lost_frames  = res_stats_q.lost_frames;
  assign axis_o.seq_min      = res_stats_q.seq_min;
  assign axis_o.seq_max      = res_stats_q.seq_max;

endmodule

// ===== test/tfd_axis_checker.sv =====
// ----------------------------------------------------------------------------
// tfd_axis_checker
// Watches the byte, axis and threshold channels of the deframer. Each byte
// transfer runs through a cycle-free model of the sync hunt and the axis
// assembly. Each completed axis queues the record the block must give. Each
// axis transfer is compared field by field against the oldest queued record.
// ----------------------------------------------------------------------------
module tfd_axis_checker import tfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tfd_byte_if  byte_i,
  tfd_axis_if  axis_i,
  tfd_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AxisBytes   = AXIS_LAST_BYTE + 1;
  localparam int          ReportLimit = 40;

  typedef enum logic [1:0] {
    HUNT_IDLE,
    HUNT_ARMED,
    HUNT_SEQ,
    HUNT_PAYLOAD
  } hunt_e;

  typedef struct packed {
    logic [2:0]         axis_index;
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic [15:0]        current_ma;
    logic               axis_alert;
    logic [7:0]         frame_seq;
    logic               last_axis;
    logic [31:0]        valid_frames;
    logic [31:0]        alert_frames;
    logic [31:0]        lost_frames;
    logic [7:0]         seq_min;
    logic [7:0]         seq_max;
  } axis_rec_t;

  axis_rec_t   pending_axes[$];

  hunt_e       hunt;
  int unsigned payload_idx;
  logic [7:0]  frame_seq;
  logic [39:0] word_bytes;
  logic        frame_alert;
  logic        first_frame;
  logic [7:0]  prev_seq;
  logic [7:0]  seq_lo;
  logic [7:0]  seq_hi;
  logic [31:0] n_valid;
  logic [31:0] n_alert;
  logic [31:0] n_lost;
  logic [15:0] threshold;

  int          fails;
  int          checked;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_model();
    hunt        = HUNT_IDLE;
    payload_idx = 0;
    frame_seq   = '0;
    word_bytes  = '0;
    frame_alert = 1'b0;
    first_frame = 1'b1;
    prev_seq    = '0;
    seq_lo      = 8'hFF;
    seq_hi      = '0;
    n_valid     = '0;
    n_alert     = '0;
    n_lost      = '0;
    threshold   = THRESHOLD_RESET;
    pending_axes.delete();
  endtask

  // fold the finished frame into the running statistics
  task automatic tally_frame();
    logic [7:0] gap;
    gap     = frame_seq - 8'd1 - prev_seq;
    n_valid = sat_add(n_valid, 32'd1);
    if (frame_alert) n_alert = sat_add(n_alert, 32'd1);
    if (frame_seq < seq_lo) seq_lo = frame_seq;
    if (frame_seq > seq_hi) seq_hi = frame_seq;
    if (!first_frame && gap != 8'd0) n_lost = sat_add(n_lost, {24'd0, gap});
    first_frame = 1'b0;
    prev_seq    = frame_seq;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    int unsigned byte_in_axis;
    int unsigned axis_no;
    axis_rec_t   rec;
    case (hunt)
      HUNT_IDLE: begin
        if (b == SYNC_FIRST) hunt = HUNT_ARMED;
      end
      HUNT_ARMED: begin
        if (b == SYNC_SECOND) hunt = HUNT_SEQ;
        else if (b != SYNC_FIRST) hunt = HUNT_IDLE;
      end
      HUNT_SEQ: begin
        frame_seq   = b;
        payload_idx = 0;
        word_bytes  = '0;
        frame_alert = 1'b0;
        hunt        = HUNT_PAYLOAD;
      end
      default: begin
        byte_in_axis = payload_idx % AxisBytes;
        axis_no      = payload_idx / AxisBytes;
        payload_idx++;
        if (byte_in_axis < AxisBytes - 1) begin
          word_bytes[8*byte_in_axis +: 8] = b;
        end else begin
          rec.axis_index = axis_no[2:0];
          rec.position   = word_bytes[15:0];
          rec.velocity   = word_bytes[31:16];
          rec.current_ma = {b, word_bytes[39:32]};
          rec.axis_alert = rec.current_ma > threshold;
          rec.last_axis  = (axis_no + 1 >= NUM_AXES_DEF);
          word_bytes     = '0;
          if (rec.axis_alert) frame_alert = 1'b1;
          // statistics on the last axis show the values after the update
          if (rec.last_axis) begin
            tally_frame();
            hunt        = HUNT_IDLE;
            payload_idx = 0;
          end
          rec.frame_seq    = frame_seq;
          rec.valid_frames = n_valid;
          rec.alert_frames = n_alert;
          rec.lost_frames  = n_lost;
          rec.seq_min      = seq_lo;
          rec.seq_max      = seq_hi;
          pending_axes     = {pending_axes, rec};
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= ReportLimit)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, want, got);
    end
  endtask

  task automatic check_axis();
    axis_rec_t want;
    checked++;
    if (pending_axes.size() == 0) begin
      fails++;
      if (fails <= ReportLimit)
        $display({"%0t ns: axis transfer with nothing expected, expected none,",
                  " actual axis %0d seq 0x%0h"},
                 $time, axis_i.axis_index, axis_i.frame_seq);
    end else begin
      want = pending_axes.pop_front();
      compare_field("axis_index",   32'(want.axis_index),   32'(axis_i.axis_index));
      compare_field("position",     32'(want.position),     32'(axis_i.position));
      compare_field("velocity",     32'(want.velocity),     32'(axis_i.velocity));
      compare_field("current_ma",   32'(want.current_ma),   32'(axis_i.current_ma));
      compare_field("axis_alert",   32'(want.axis_alert),   32'(axis_i.axis_alert));
      compare_field("frame_seq",    32'(want.frame_seq),    32'(axis_i.frame_seq));
      compare_field("last_axis",    32'(want.last_axis),    32'(axis_i.last_axis));
      compare_field("valid_frames", want.valid_frames,      axis_i.valid_frames);
      compare_field("alert_frames", want.alert_frames,      axis_i.alert_frames);
      compare_field("lost_frames",  want.lost_frames,       axis_i.lost_frames);
      compare_field("seq_min",      32'(want.seq_min),      32'(axis_i.seq_min));
      compare_field("seq_max",      32'(want.seq_max),      32'(axis_i.seq_max));
    end
  endtask

  // compare first: a result on this edge never belongs to a byte on this edge;
  // a threshold write on this edge applies from the next byte on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (axis_i.valid && axis_i.ready) check_axis();
      if (byte_i.valid && byte_i.ready) deframe_byte(byte_i.data_byte);
      if (cfg_i.valid && cfg_i.ready) threshold = cfg_i.current_threshold_ma;
      fail_count_o <= fails;
      pending_o    <= pending_axes.size();
      checked_o    <= checked;
    end
  end

endmodule

// ===== test/telemetry_frame_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_tb
// Drives sync hunt corner cases, directed frames at field extremes and a long
// run of random frames, noise, broken syncs and truncated frames through the
// deframer. The alert threshold is swept between runs of traffic. Byte
// bursts and result back-pressure vary at random; tfd_axis_checker judges
// every result.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tfd_pkg::*;

  localparam int ClkPeriod       = 8;
  localparam int ResetCycles     = 10;
  localparam int SettleCycles    = 8;
  localparam int ByteTarget      = 1200;
  localparam int AxisBytes       = AXIS_LAST_BYTE + 1;
  localparam int FrameBytes      = NUM_AXES_DEF * AxisBytes;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum int {CUR_QUIET, CUR_EDGE, CUR_WILD} cur_style_e;

  logic clk;
  logic rst_n;

  tfd_byte_if byte_ch ();
  tfd_axis_if axis_ch ();
  tfd_cfg_if  cfg_ch ();

  int fail_count;
  int pending;
  int checked;

  telemetry_frame_deframer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_ch),
    .axis_o (axis_ch),
    .cfg_i  (cfg_ch)
  );

  tfd_axis_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .byte_i       (byte_ch),
    .axis_i       (axis_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  logic [15:0] ax_pos[NUM_AXES_DEF];
  logic [15:0] ax_vel[NUM_AXES_DEF];
  logic [15:0] ax_cur[NUM_AXES_DEF];
  logic [15:0] cur_thr;
  logic [7:0]  last_seq;
  int          burst_left;
  int          bytes_total;
  int          frame_bytes;
  int          frames_sent;
  int          settings_used;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result back-pressure: switch at random between stall patterns
  initial begin
    rx_mode_e mode;
    int       span;
    int       tick;
    axis_ch.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          RX_STREAM: axis_ch.ready <= 1'b1;
          RX_COIN:   axis_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: axis_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   axis_ch.ready <= (tick % 5 == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    burst_left--;
    bytes_total++;
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // sync pair, sequence byte, then payload_len bytes of the staged axes
  task automatic send_frame(input logic [7:0] seq, input int payload_len);
    logic [47:0] rec;
    int          k;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(seq);
    for (k = 0; k < payload_len; k++) begin
      rec = {ax_cur[k / AxisBytes], ax_vel[k / AxisBytes], ax_pos[k / AxisBytes]};
      send_byte(rec[8 * (k % AxisBytes) +: 8]);
    end
    frame_bytes += 3 + payload_len;
    frames_sent++;
    last_seq = seq;
  endtask

  task automatic fill_axes(input cur_style_e style);
    int a;
    for (a = 0; a < NUM_AXES_DEF; a++) begin
      ax_pos[a] = 16'($urandom);
      ax_vel[a] = 16'($urandom);
      case (style)
        CUR_QUIET: ax_cur[a] = 16'($urandom_range(0, cur_thr));
        CUR_EDGE: begin
          case ($urandom_range(0, 5))
            0:       ax_cur[a] = cur_thr;
            1:       ax_cur[a] = (cur_thr == 16'hFFFF) ? cur_thr : cur_thr + 16'd1;
            2:       ax_cur[a] = (cur_thr == 16'h0000) ? cur_thr : cur_thr - 16'd1;
            3:       ax_cur[a] = 16'h0000;
            4:       ax_cur[a] = 16'hFFFF;
            default: ax_cur[a] = 16'($urandom);
          endcase
        end
        default: ax_cur[a] = 16'($urandom);
      endcase
    end
  endtask

  // mostly in order, with repeats, jumps and small gaps mixed in
  function automatic logic [7:0] next_seq();
    case ($urandom_range(0, 11))
      0:       return last_seq;
      1:       return 8'($urandom);
      2, 3:    return last_seq + 8'($urandom_range(2, 40));
      default: return last_seq + 8'd1;
    endcase
  endfunction

  // hold bytes off until every result is out and the block has settled
  task automatic go_idle();
    byte_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] v);
    go_idle();
    cfg_ch.valid                <= 1'b1;
    cfg_ch.current_threshold_ma <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_thr = v;
    settings_used++;
  endtask

  initial begin
    int          phase;
    int          pick;
    logic [15:0] thr;
    logic [7:0]  b;
    rst_n                       <= 1'b0;
    byte_ch.valid               <= 1'b0;
    byte_ch.data_byte           <= '0;
    cfg_ch.valid                <= 1'b0;
    cfg_ch.current_threshold_ma <= '0;
    cur_thr       = THRESHOLD_RESET;
    last_seq      = '0;
    burst_left    = 0;
    bytes_total   = 0;
    frame_bytes   = 0;
    frames_sent   = 0;
    settings_used = 0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored bytes, a broken sync, then a sync byte repeated before the pair
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h13);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);

    // field extremes, sync bytes inside the payload, reset threshold edges
    ax_pos = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h55AA, 16'hAAAA};
    ax_vel = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'hAA55, 16'h5555};
    ax_cur = '{16'd5000, 16'd5001, 16'h0000, 16'hFFFF, 16'd4999, 16'h55AA};
    send_frame(8'hFF, FrameBytes);
    send_frame(8'h00, FrameBytes);
    fill_axes(CUR_QUIET);
    send_frame(8'h00, FrameBytes);

    set_threshold(16'h0000);
    fill_axes(CUR_EDGE);
    ax_cur[0] = 16'h0000;
    ax_cur[1] = 16'h0001;
    send_frame(8'h05, FrameBytes);

    set_threshold(16'hFFFF);
    fill_axes(CUR_WILD);
    ax_cur[5] = 16'hFFFF;
    send_frame(8'h80, FrameBytes);

    phase = 0;
    while (bytes_total < ByteTarget) begin
      case (phase % 5)
        0:       thr = 16'h0000;
        1:       thr = 16'hFFFF;
        2:       thr = THRESHOLD_RESET;
        default: thr = 16'($urandom);
      endcase
      set_threshold(thr);
      repeat ($urandom_range(3, 7)) begin
        if (bytes_total >= ByteTarget) break;
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
          if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
          fill_axes(cur_style_e'($urandom_range(0, 2)));
          send_frame(next_seq(), FrameBytes);
        end else if (pick < 17) begin
          send_noise($urandom_range(1, 8));
        end else if (pick < 19) begin
          b = 8'($urandom);
          if (b == SYNC_SECOND) b = 8'h00;
          send_byte(SYNC_FIRST);
          send_byte(b);
        end else begin
          // truncated frame: the next frame's bytes land in its payload
          fill_axes(CUR_WILD);
          send_frame(next_seq(), $urandom_range(0, FrameBytes - 1));
        end
      end
      phase++;
    end

    // trailing partial frame with half of the payload
    fill_axes(CUR_EDGE);
    send_frame(next_seq(), FrameBytes / 2);
    go_idle();

    $display("Stimulus: %0d bytes, %0d frame starts, %0d threshold settings",
             bytes_total, frames_sent, settings_used);
    $display("Checked %0d axis results, %0d field errors", checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== telemetry_frame_deframer.f =====
sv/tfd_pkg.sv
sv/tfd_if.sv
sv/tfd_hunt.sv
sv/tfd_stats.sv
sv/telemetry_frame_deframer.sv
test/tfd_axis_checker.sv
test/telemetry_frame_deframer_tb.sv
